[src/flbp_pkg.sv]
// Shared types and constants for the framed link byte parser.
`timescale 1ns / 1ps
`default_nettype none

package flbp_pkg;

    // Sizes
    localparam int BUFFER_DEPTH_DEF = 256;
    localparam int CMD_DEPTH        = 4;
    localparam int CMD_AW           = $clog2(CMD_DEPTH);
    localparam int RES_DEPTH        = 4;
    localparam int RES_AW           = $clog2(RES_DEPTH);

    // Frame constants
    localparam logic [7:0] FRAME_OVERHEAD   = 8'd4;
    localparam logic [7:0] START_BYTE_RESET = 8'd153;

    // Action codes
    localparam logic [1:0] ACT_RX      = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    // One input transaction
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic       frame_complete;
        logic       frame_error;
        logic       overrun;
        logic       message_held;
        logic [7:0] payload_length;
        logic [7:0] read_data;
        logic [7:0] error_count;
        logic [7:0] overrun_count;
        logic [2:0] parser_phase;
    } t_out_item;

    // Classified command between front and core
    typedef struct packed {
        logic       is_rx;
        logic       is_read;
        logic       is_release;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } t_cmd;

    // Fill level of the result queue, seen by the core
    typedef struct packed {
        logic [RES_AW:0] count;
    } t_resq_status;

endpackage

`default_nettype wire

[src/flbp_front.sv]
// Front end: decodes incoming transactions and queues them for the core.
`timescale 1ns / 1ps
`default_nettype none

module flbp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire flbp_pkg::t_in_item i_item,
    output logic                   o_cmd_valid,
    output flbp_pkg::t_cmd         o_cmd,
    input  wire logic              i_cmd_pop
);

    flbp_pkg::t_cmd                r_queue [flbp_pkg::CMD_DEPTH];
    logic [flbp_pkg::CMD_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [flbp_pkg::CMD_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [flbp_pkg::CMD_AW:0]     r_count, n_count;
    flbp_pkg::t_cmd                w_cmd;
    logic                          w_push;
    logic                          w_pop;

    // Classify the action into command flags: at most one is set, none for an unused code
    always_comb begin
        w_cmd.is_rx      = (i_item.action == flbp_pkg::ACT_RX);
        w_cmd.is_read    = (i_item.action == flbp_pkg::ACT_READ);
        w_cmd.is_release = (i_item.action == flbp_pkg::ACT_RELEASE);
        w_cmd.data_byte  = i_item.data_byte;
        w_cmd.read_index = i_item.read_index;
    end

    assign o_full      = (r_count == (flbp_pkg::CMD_AW + 1)'(flbp_pkg::CMD_DEPTH));
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_queue[r_rd_ptr];

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (flbp_pkg::CMD_AW + 1)'(w_push)
                           - (flbp_pkg::CMD_AW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the classified command
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

[src/flbp_core.sv]
// Core: frame parser state machine, checksums, counters and payload store.
`timescale 1ns / 1ps
`default_nettype none

module flbp_core #(
    parameter int BUFFER_DEPTH = flbp_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [7:0]             i_cfg_data,
    input  wire logic                   i_cmd_valid,
    input  wire flbp_pkg::t_cmd         i_cmd,
    output logic                        o_cmd_pop,
    input  wire flbp_pkg::t_resq_status i_resq,
    output logic                        o_res_push,
    output flbp_pkg::t_out_item         o_res_data
);

    localparam int         AW        = $clog2(BUFFER_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(BUFFER_DEPTH);
    localparam int         CW        = flbp_pkg::RES_AW + 1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_PAY   = 3'd2,
        PH_GOTP  = 3'd3,
        PH_GOTA  = 3'd4
    } t_phase;

    t_phase              r_phase, n_phase;
    logic                r_held, n_held;
    logic [7:0]          r_len, n_len;
    logic [7:0]          r_pos, n_pos;
    logic [7:0]          r_sum_a, n_sum_a;
    logic [7:0]          r_sum_b, n_sum_b;
    logic [7:0]          r_err_cnt, n_err_cnt;
    logic [7:0]          r_ovr_cnt, n_ovr_cnt;
    logic [7:0]          r_start_byte;
    logic                r_stage_valid;
    flbp_pkg::t_out_item r_stage, n_stage;
    logic                r_rd_ok;
    logic [7:0]          r_mem_q;
    logic [7:0]          r_store [BUFFER_DEPTH];

    logic                w_fire;
    logic [CW:0]         w_credit_used;
    logic                w_done, w_bad, w_ovr;
    logic [7:0]          w_sum_a_pay;
    logic [7:0]          w_pos_inc;
    logic [8:0]          w_len_ext;
    logic                w_store_wr;
    logic                w_idx_ok;

    // Take a command only when the result queue has room for it and the stage
    assign w_credit_used = {1'b0, i_resq.count} + {{CW{1'b0}}, r_stage_valid};
    assign w_fire        = i_cmd_valid && (w_credit_used < (CW + 1)'(flbp_pkg::RES_DEPTH));
    assign o_cmd_pop     = w_fire;

    assign w_sum_a_pay = r_sum_a + i_cmd.data_byte;
    assign w_pos_inc   = r_pos + 8'd1;
    assign w_len_ext   = {1'b0, i_cmd.data_byte} - {1'b0, flbp_pkg::FRAME_OVERHEAD};
    assign w_store_wr  = w_fire && i_cmd.is_rx && (r_phase == PH_PAY)
                         && ({1'b0, r_pos} < DEPTH_LIM);
    assign w_idx_ok    = ({1'b0, i_cmd.read_index} < DEPTH_LIM);

    // Work out the next parser state for the command at the queue head
    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_len     = r_len;
        n_pos     = r_pos;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_err_cnt = r_err_cnt;
        n_ovr_cnt = r_ovr_cnt;
        w_done    = 1'b0;
        w_bad     = 1'b0;
        w_ovr     = 1'b0;

        if (w_fire && i_cmd.is_rx) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_cmd.data_byte == r_start_byte) begin
                        n_phase = PH_START;
                    end
                end
                PH_START: begin
                    if (r_held) begin
                        w_ovr     = 1'b1;
                        w_bad     = 1'b1;
                        n_ovr_cnt = r_ovr_cnt + 8'd1;
                    end else if (i_cmd.data_byte < flbp_pkg::FRAME_OVERHEAD
                                 || w_len_ext > DEPTH_LIM) begin
                        w_bad = 1'b1;
                    end else begin
                        n_len   = w_len_ext[7:0];
                        n_sum_a = i_cmd.data_byte;
                        n_sum_b = i_cmd.data_byte;
                        n_pos   = 8'd0;
                        n_phase = (w_len_ext[7:0] == 8'd0) ? PH_GOTP : PH_PAY;
                    end
                end
                PH_PAY: begin
                    n_sum_a = w_sum_a_pay;
                    n_sum_b = r_sum_b + w_sum_a_pay;
                    n_pos   = w_pos_inc;
                    if (w_pos_inc == r_len) begin
                        n_phase = PH_GOTP;
                    end
                end
                PH_GOTP: begin
                    if (i_cmd.data_byte != r_sum_a) begin
                        w_bad = 1'b1;
                    end else begin
                        n_phase = PH_GOTA;
                    end
                end
                PH_GOTA: begin
                    if (i_cmd.data_byte != r_sum_b) begin
                        w_bad = 1'b1;
                    end else begin
                        n_held  = 1'b1;
                        w_done  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    w_bad = 1'b1;
                end
            endcase

            // Drop the frame and restart on any error
            if (w_bad) begin
                n_err_cnt = r_err_cnt + 8'd1;
                n_phase   = PH_IDLE;
            end
        end else if (w_fire && i_cmd.is_release) begin
            n_held = 1'b0;
        end

        n_stage.frame_complete = w_done;
        n_stage.frame_error    = w_bad;
        n_stage.overrun        = w_ovr;
        n_stage.message_held   = n_held;
        n_stage.payload_length = n_len;
        n_stage.read_data      = 8'd0;
        n_stage.error_count    = n_err_cnt;
        n_stage.overrun_count  = n_ovr_cnt;
        n_stage.parser_phase   = n_phase;
    end

    // Hold parser state, configuration and the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_held        <= 1'b0;
            r_len         <= 8'd0;
            r_pos         <= 8'd0;
            r_sum_a       <= 8'd0;
            r_sum_b       <= 8'd0;
            r_err_cnt     <= 8'd0;
            r_ovr_cnt     <= 8'd0;
            r_start_byte  <= flbp_pkg::START_BYTE_RESET;
            r_stage_valid <= 1'b0;
            r_stage       <= '0;
            r_rd_ok       <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_held        <= n_held;
            r_len         <= n_len;
            r_pos         <= n_pos;
            r_sum_a       <= n_sum_a;
            r_sum_b       <= n_sum_b;
            r_err_cnt     <= n_err_cnt;
            r_ovr_cnt     <= n_ovr_cnt;
            r_stage_valid <= w_fire;
            if (w_fire) begin
                r_stage <= n_stage;
                r_rd_ok <= i_cmd.is_read && w_idx_ok;
            end
            if (i_cfg_we) begin
                r_start_byte <= i_cfg_data;
            end
        end
    end

    // Payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_store_wr) begin
            r_store[r_pos[AW-1:0]] <= i_cmd.data_byte;
        end
        if (w_fire && i_cmd.is_read) begin
            r_mem_q <= r_store[i_cmd.read_index[AW-1:0]];
        end
    end

    // Merge the read data into the staged result
    always_comb begin
        o_res_data           = r_stage;
        o_res_data.read_data = r_rd_ok ? r_mem_q : 8'd0;
    end
    assign o_res_push = r_stage_valid;

endmodule

`default_nettype wire

[src/flbp_res_queue.sv]
// Result queue: holds finished result transactions until they are popped.
`timescale 1ns / 1ps
`default_nettype none

module flbp_res_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire flbp_pkg::t_out_item  i_data,
    output flbp_pkg::t_resq_status    o_status,
    output logic                      o_empty,
    output flbp_pkg::t_out_item       o_data,
    input  wire logic                 i_pop
);

    flbp_pkg::t_out_item           r_queue [flbp_pkg::RES_DEPTH];
    logic [flbp_pkg::RES_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [flbp_pkg::RES_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [flbp_pkg::RES_AW:0]     r_count, n_count;
    logic                          w_pop;

    assign o_empty        = (r_count == '0);
    assign w_pop          = i_pop && !o_empty;
    assign o_data         = r_queue[r_rd_ptr];
    assign o_status.count = r_count;

    // Advance pointers and fill level; the core never pushes when full
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (flbp_pkg::RES_AW + 1)'(i_push)
                           - (flbp_pkg::RES_AW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_queue[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[src/framed_link_byte_parser_top.sv]
// Top level of the framed link byte parser.
`timescale 1ns / 1ps
`default_nettype none

// Framed link byte parser. Each input transaction (receive a link byte, read a
// stored payload byte, or release the held message) yields exactly one result
// transaction, in order. The block takes one transaction per clock unless the
// result queue backs up: the front end queues classified commands, the core
// executes one per cycle while the result queue has room, through its parser
// update and the one write and one read port of the payload store, and a
// four-entry result queue decouples the consumer. Each result is registered in
// the core's result stage and then in the result queue. The start byte
// register may be written only while no transaction is in flight.
module framed_link_byte_parser_top #(
    parameter int BUFFER_DEPTH = flbp_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire flbp_pkg::t_in_item  i_item,
    input  wire logic                i_cfg_we,
    input  wire logic [7:0]          i_cfg_data,
    input  wire logic                pop,
    output logic                     empty,
    output flbp_pkg::t_out_item      o_result
);

    logic                   w_cmd_valid;
    flbp_pkg::t_cmd         w_cmd;
    logic                   w_cmd_pop;
    flbp_pkg::t_resq_status w_resq;
    logic                   w_res_push;
    flbp_pkg::t_out_item    w_res_data;

    // Accept and classify
    flbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Execute
    flbp_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_resq      (w_resq),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_data)
    );

    // Queue results
    flbp_res_queue u_res_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_push),
        .i_data   (w_res_data),
        .o_status (w_resq),
        .o_empty  (empty),
        .o_data   (o_result),
        .i_pop    (pop)
    );

`ifndef SYNTHESIS
    // A frame cannot both complete and fail on one byte
    a_done_not_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_result.frame_complete && o_result.frame_error))
        else $error("result reports both frame complete and frame error");

    // An overrun always counts as an error
    a_ovr_is_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.overrun) |-> o_result.frame_error)
        else $error("overrun reported without frame error");

    // Reset leaves the result queue empty and the command queue not full
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");
`endif

endmodule

`default_nettype wire

[sim/flbp_link_checker.sv]
// Checker that predicts the parser's result transactions and compares them.
`timescale 1ns / 1ps
`default_nettype none

module flbp_link_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic                i_full,
    input  wire flbp_pkg::t_in_item  i_item,
    input  wire logic                i_cfg_we,
    input  wire logic [7:0]          i_cfg_data,
    input  wire logic                i_pop,
    input  wire logic                i_empty,
    input  wire flbp_pkg::t_out_item i_result,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_stored_bytes
);

    // Parser phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_SUM_A   = 3'd3;
    localparam logic [2:0] PH_SUM_B   = 3'd4;

    // Shadow copy of the parser state
    logic [7:0] start_val;
    logic [2:0] phase;
    logic       held;
    logic [7:0] frame_len;
    logic [7:0] byte_pos;
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    logic [7:0] err_total;
    logic [7:0] ovr_total;
    logic [7:0] payload_mem [0:255];

    // Reports predicted but not yet seen on the result side
    flbp_pkg::t_out_item parser_reports[$];

    // Advance the shadow parser by one transaction and form its report
    task automatic advance_parser(input flbp_pkg::t_in_item it,
                                  output flbp_pkg::t_out_item rep);
        logic       done;
        logic       err;
        logic       ovr;
        logic       restart;
        logic [7:0] rd;
        done    = 1'b0;
        err     = 1'b0;
        ovr     = 1'b0;
        restart = 1'b0;
        rd      = 8'd0;
        case (it.action)
            flbp_pkg::ACT_RX: begin
                case (phase)
                    PH_IDLE: begin
                        if (it.data_byte == start_val)
                            phase = PH_LENGTH;
                    end
                    PH_LENGTH: begin
                        // A new frame while one is held is an overrun and an error
                        if (held) begin
                            ovr_total = ovr_total + 8'd1;
                            ovr       = 1'b1;
                            restart   = 1'b1;
                        end else if (it.data_byte < flbp_pkg::FRAME_OVERHEAD) begin
                            restart = 1'b1;
                        end else begin
                            frame_len = it.data_byte - flbp_pkg::FRAME_OVERHEAD;
                            sum_a     = it.data_byte;
                            sum_b     = it.data_byte;
                            byte_pos  = 8'd0;
                            phase     = (frame_len == 8'd0) ? PH_SUM_A : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        payload_mem[byte_pos] = it.data_byte;
                        if (int'(byte_pos) >= o_stored_bytes)
                            o_stored_bytes = int'(byte_pos) + 1;
                        sum_a    = sum_a + it.data_byte;
                        sum_b    = sum_b + sum_a;
                        byte_pos = byte_pos + 8'd1;
                        if (byte_pos == frame_len)
                            phase = PH_SUM_A;
                    end
                    PH_SUM_A: begin
                        if (it.data_byte != sum_a)
                            restart = 1'b1;
                        else
                            phase = PH_SUM_B;
                    end
                    PH_SUM_B: begin
                        if (it.data_byte != sum_b) begin
                            restart = 1'b1;
                        end else begin
                            held  = 1'b1;
                            done  = 1'b1;
                            phase = PH_IDLE;
                        end
                    end
                    default: restart = 1'b1;
                endcase
                if (restart) begin
                    err_total = err_total + 8'd1;
                    err       = 1'b1;
                    phase     = PH_IDLE;
                end
            end
            flbp_pkg::ACT_READ:    rd = payload_mem[it.read_index];
            flbp_pkg::ACT_RELEASE: held = 1'b0;
            default: ;
        endcase
        rep.frame_complete = done;
        rep.frame_error    = err;
        rep.overrun        = ovr;
        rep.message_held   = held;
        rep.payload_length = frame_len;
        rep.read_data      = rd;
        rep.error_count    = err_total;
        rep.overrun_count  = ovr_total;
        rep.parser_phase   = phase;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            o_fail_count = o_fail_count + 1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Track configuration, compare popped results, predict pushed transactions
    always @(posedge i_clk) begin : watch
        flbp_pkg::t_out_item oldest;
        flbp_pkg::t_out_item report;
        if (!i_rst_n) begin
            start_val      = flbp_pkg::START_BYTE_RESET;
            phase          = PH_IDLE;
            held           = 1'b0;
            frame_len      = 8'd0;
            byte_pos       = 8'd0;
            sum_a          = 8'd0;
            sum_b          = 8'd0;
            err_total      = 8'd0;
            ovr_total      = 8'd0;
            o_stored_bytes = 0;
            o_fail_count   = 0;
            parser_reports.delete();
        end else begin
            if (i_cfg_we)
                start_val = i_cfg_data;
            if (i_pop && !i_empty) begin
                if (parser_reports.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: result with none expected, actual %h", $time, i_result);
                end else begin
                    oldest = parser_reports.pop_front();
                    check_field("frame_complete", 32'(oldest.frame_complete),
                                32'(i_result.frame_complete));
                    check_field("frame_error", 32'(oldest.frame_error),
                                32'(i_result.frame_error));
                    check_field("overrun", 32'(oldest.overrun), 32'(i_result.overrun));
                    check_field("message_held", 32'(oldest.message_held),
                                32'(i_result.message_held));
                    check_field("payload_length", 32'(oldest.payload_length),
                                32'(i_result.payload_length));
                    check_field("read_data", 32'(oldest.read_data),
                                32'(i_result.read_data));
                    check_field("error_count", 32'(oldest.error_count),
                                32'(i_result.error_count));
                    check_field("overrun_count", 32'(oldest.overrun_count),
                                32'(i_result.overrun_count));
                    check_field("parser_phase", 32'(oldest.parser_phase),
                                32'(i_result.parser_phase));
                end
            end
            if (i_push && !i_full) begin
                advance_parser(i_item, report);
                parser_reports.push_back(report);
            end
        end
        o_pending = parser_reports.size();
    end

endmodule

`default_nettype wire

[sim/tb_framed_link_byte_parser_top.sv]
// Testbench top for the framed link byte parser: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_framed_link_byte_parser_top;

    // Action code the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Ways to spoil a frame
    localparam int FAULT_NONE   = 0;
    localparam int FAULT_SUM_A  = 1;
    localparam int FAULT_SUM_B  = 2;
    localparam int FAULT_LENGTH = 3;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                push       = 1'b0;
    logic                pop        = 1'b0;
    logic                i_cfg_we   = 1'b0;
    logic [7:0]          i_cfg_data = 8'd0;
    flbp_pkg::t_in_item  i_item     = '0;
    logic                full;
    logic                empty;
    flbp_pkg::t_out_item o_result;

    int         fail_count;
    int         pending;
    int         stored_bytes;

    bit         idle_en     = 1'b1;
    bit         held_hint   = 1'b0;
    logic [7:0] frame_start = flbp_pkg::START_BYTE_RESET;
    int         item_count  = 0;

    framed_link_byte_parser_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .pop        (pop),
        .empty      (empty),
        .o_result   (o_result)
    );

    flbp_link_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_pop          (pop),
        .i_empty        (empty),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_stored_bytes (stored_bytes)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Give up on a hung run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Drain results, stalling in random bursts until the final stretch
    initial begin : result_side
        int stall;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall == 0 && idle_en && $urandom_range(0, 11) == 0)
                stall = $urandom_range(1, 18);
            if (stall > 0) begin
                pop <= 1'b0;
                stall = stall - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one transaction from a falling edge and hold it until taken
    task automatic send_cmd(input logic [1:0] act, input logic [7:0] byte_val,
                            input logic [7:0] idx);
        flbp_pkg::t_in_item it;
        bit                 taken;
        it.action     = act;
        it.data_byte  = byte_val;
        it.read_index = idx;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        taken  = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !full;
            @(negedge i_clk);
        end
        if (act != ACT_UNUSED)
            item_count = item_count + 1;
    endtask

    task automatic rx_byte(input logic [7:0] d);
        send_cmd(flbp_pkg::ACT_RX, d, 8'($urandom_range(0, 255)));
    endtask

    task automatic release_msg();
        send_cmd(flbp_pkg::ACT_RELEASE, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    endtask

    // Send a frame of n payload bytes, optionally spoilt
    task automatic send_frame(input int n, input int fault, input bit extremes);
        logic [7:0] len;
        logic [7:0] sa;
        logic [7:0] sb;
        logic [7:0] d;
        len = 8'(n + 4);
        if (fault == FAULT_LENGTH)
            len = 8'($urandom_range(0, 3));
        rx_byte(frame_start);
        rx_byte(len);
        if (fault == FAULT_LENGTH)
            return;
        sa = len;
        sb = len;
        for (int k = 0; k < n; k++) begin
            d  = extremes ? ((k % 2 == 0) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
            rx_byte(d);
            sa = sa + d;
            sb = sb + sa;
        end
        rx_byte((fault == FAULT_SUM_A) ? (sa ^ 8'($urandom_range(1, 255))) : sa);
        if (fault == FAULT_SUM_A)
            return;
        rx_byte((fault == FAULT_SUM_B) ? (sb ^ 8'($urandom_range(1, 255))) : sb);
    endtask

    // Stop sending until every result is back, then let the pipe settle
    task automatic settle_link();
        push <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_start(input logic [7:0] v);
        settle_link();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_start = v;
    endtask

    initial begin : stimulus
        int n;
        int pick;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty payload, release, extreme bytes, reads, overrun,
        // bad checksum, bad length, ignored action
        send_frame(0, FAULT_NONE, 1'b0);
        release_msg();
        send_frame(2, FAULT_NONE, 1'b1);
        send_cmd(flbp_pkg::ACT_READ, 8'h00, 8'd0);
        send_cmd(flbp_pkg::ACT_READ, 8'hFF, 8'd1);
        send_frame(0, FAULT_NONE, 1'b0);
        release_msg();
        send_frame(1, FAULT_SUM_A, 1'b0);
        send_frame(0, FAULT_LENGTH, 1'b0);
        send_cmd(ACT_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

        // Random traffic in four segments, each under its own start byte
        for (int seg = 0; seg < 4; seg++) begin
            case (seg)
                0: write_start(8'hFF);
                1: write_start(8'h00);
                2: write_start(8'($urandom_range(0, 255)));
                default: begin
                    write_start(flbp_pkg::START_BYTE_RESET);
                    idle_en = 1'b0;
                end
            endcase
            held_hint = 1'b1;
            // Largest payload once, so the upper store entries get filled
            if (seg == 0) begin
                release_msg();
                send_frame(251, FAULT_NONE, 1'b0);
            end
            while (item_count < 25 + (seg + 1) * 107) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    if (held_hint && $urandom_range(0, 3) != 0)
                        release_msg();
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                    : $urandom_range(0, 12);
                    send_frame(n, FAULT_NONE, $urandom_range(0, 7) == 0);
                    held_hint = 1'b1;
                end else if (pick < 57) begin
                    send_frame($urandom_range(0, 8), $urandom_range(FAULT_SUM_A, FAULT_LENGTH),
                               1'b0);
                end else if (pick < 75) begin
                    repeat ($urandom_range(1, 4)) begin
                        if (stored_bytes > 0)
                            send_cmd(flbp_pkg::ACT_READ, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, stored_bytes - 1)));
                    end
                end else if (pick < 85) begin
                    release_msg();
                    held_hint = 1'b0;
                end else begin
                    // Line noise and the odd ignored action
                    repeat ($urandom_range(1, 4)) rx_byte(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 2) == 0)
                        send_cmd(ACT_UNUSED, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                end
            end
        end

        push <= 1'b0;
        wait (pending == 0);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
